// File: sv/pdco_pkg.sv
package pdco_pkg;

    localparam int ADDR_W = 19;
    localparam int RGB_W  = 16;
    localparam int CPOS_W = 14;

    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_PALETTE = 2'd1,
        OP_CURSOR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CFG_PAGE_WIDTH    = 3'd0,
        CFG_PAGE_HEIGHT   = 3'd1,
        CFG_CURSOR_WIDTH  = 3'd2,
        CFG_CURSOR_HEIGHT = 3'd3,
        CFG_CURSOR_LEFT   = 3'd4,
        CFG_CURSOR_TOP    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        op_t         operation;
        logic [7:0]  colour_index;
        logic [7:0]  palette_slot;
        logic [5:0]  red_six;
        logic [5:0]  green_six;
        logic [5:0]  blue_six;
        logic [11:0] cursor_slot;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic [RGB_W-1:0]  rgb565;
        logic              frame_last;
    } out_item_t;

    // geometry derived from the configuration registers
    typedef struct packed {
        logic [10:0]        pw;
        logic [10:0]        ph;
        logic [11:0]        cw;
        logic [11:0]        ch;
        logic [11:0]        ox;
        logic [11:0]        oy;
        logic [6:0]         cur_w;
        logic [6:0]         cur_h;
        logic signed [10:0] cur_left;
        logic signed [10:0] cur_top;
        logic               cur_ok;
    } geom_t;

    // classified item passed from front to back
    typedef struct packed {
        op_t               kind;
        logic [7:0]        index;
        logic [7:0]        pslot;
        logic [RGB_W-1:0]  entry;
        logic [CPOS_W-1:0] cpos;
        logic [9:0]        col;
        logic [9:0]        row;
        logic [6:0]        dx;
        logic [6:0]        dy;
        logic              hit;
        logic              last;
    } mid_item_t;

    function automatic logic [10:0] clamp_size(input logic [10:0] v);
        logic [10:0] r;
        if (v == 11'd0)
        begin
            r = 11'd1;
        end
        else if (v > 11'd1024)
        begin
            r = 11'd1024;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: sv/pdco_fifo.sv
module pdco_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr,
    input  logic [WIDTH-1:0]               wdata,
    output logic                           full,
    input  logic                           rd,
    output logic [WIDTH-1:0]               rdata,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rdata = mem[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/pdco_front.sv
module pdco_front #(
    parameter int CURSOR_PIXELS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pdco_pkg::in_item_t   item,
    input  pdco_pkg::geom_t      geom,
    output logic                 mq_push,
    output pdco_pkg::mid_item_t  mq_item,
    input  logic                 mq_full
);
    import pdco_pkg::*;

    logic [9:0]         col_reg, col_next;
    logic [9:0]         row_reg, row_next;
    logic [10:0]        col_inc, row_inc;
    logic               accept;
    logic               visible;
    logic signed [12:0] dx, dy;
    logic               hit_x, hit_y;

    assign full   = mq_full;
    assign accept = push && !mq_full;

    assign col_inc = {1'b0, col_reg} + 11'd1;
    assign row_inc = {1'b0, row_reg} + 11'd1;
    assign visible = ({2'b00, col_reg} < geom.cw) && ({2'b00, row_reg} < geom.ch);

    // position relative to the cursor image corner
    assign dx    = $signed({3'b000, col_reg}) - $signed({{2{geom.cur_left[10]}}, geom.cur_left});
    assign dy    = $signed({3'b000, row_reg}) - $signed({{2{geom.cur_top[10]}}, geom.cur_top});
    assign hit_x = !dx[12] && (dx[11:0] < {5'b00000, geom.cur_w});
    assign hit_y = !dy[12] && (dy[11:0] < {5'b00000, geom.cur_h});

    always_comb
    begin
        mq_item.kind  = item.operation;
        mq_item.index = item.colour_index;
        mq_item.pslot = item.palette_slot;
        mq_item.entry = {item.red_six[5:1], item.green_six, item.blue_six[5:1]};
        mq_item.cpos  = CPOS_W'(item.cursor_slot);
        mq_item.col   = col_reg;
        mq_item.row   = row_reg;
        mq_item.dx    = dx[6:0];
        mq_item.dy    = dy[6:0];
        mq_item.hit   = geom.cur_ok && hit_x && hit_y;
        mq_item.last  = ({2'b00, col_reg} == geom.cw - 12'd1)
                     && ({2'b00, row_reg} == geom.ch - 12'd1);

        mq_push  = 1'b0;
        col_next = col_reg;
        row_next = row_reg;
        unique case (item.operation)
            OP_PIXEL:
            begin
                mq_push = accept && visible;
                if (accept)
                begin
                    if (col_inc >= geom.pw)
                    begin
                        col_next = '0;
                        row_next = (row_inc >= geom.ph) ? '0 : row_inc[9:0];
                    end
                    else
                    begin
                        col_next = col_inc[9:0];
                    end
                end
            end
            OP_PALETTE:
            begin
                mq_push = accept;
            end
            OP_CURSOR:
            begin
                mq_push = accept && ({3'b000, item.cursor_slot} < 15'(CURSOR_PIXELS));
            end
            default:
            begin
                mq_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: sv/pdco_back.sv
module pdco_back #(
    parameter int CANVAS_WIDTH  = 800,
    parameter int CURSOR_PIXELS = 4096,
    parameter int OUT_DEPTH     = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               mq_empty,
    input  pdco_pkg::mid_item_t                mq_item,
    output logic                               mq_pop,
    input  pdco_pkg::geom_t                    geom,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
    output logic                               op_push,
    output pdco_pkg::out_item_t                op_item
);
    import pdco_pkg::*;

    localparam int CA_W = $clog2(CURSOR_PIXELS);
    localparam int OCW  = $clog2(OUT_DEPTH+1);
    localparam int MW   = 12 + $clog2(CANVAS_WIDTH+1);
    localparam int FP_W = (MW > ADDR_W) ? MW : ADDR_W;

    logic [7:0]       cmem [CURSOR_PIXELS];
    logic [RGB_W-1:0] pmem [256];

    // stage 1: cursor store access and address arithmetic
    logic             s1_valid_reg;
    mid_item_t        s1_reg;
    logic [14:0]      pos;
    logic             pos_ok;
    logic [11:0]      row_sum;
    logic [FP_W-1:0]  addr_full;
    logic [7:0]       crd_reg;

    // stage 2: palette access
    logic              s2_valid_reg;
    op_t               s2_kind_reg;
    logic [7:0]        s2_index_reg;
    logic [7:0]        s2_pslot_reg;
    logic [RGB_W-1:0]  s2_entry_reg;
    logic              s2_hit_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic              s2_last_reg;
    logic [7:0]        paddr;
    logic [RGB_W-1:0]  prd_reg;

    // stage 3: result into the output queue
    logic              s3_valid_reg;
    logic [ADDR_W-1:0] s3_addr_reg;
    logic              s3_last_reg;

    logic              s1_pixel, s2_pixel;
    logic [1:0]        n_flight;
    logic [OCW:0]      used;

    assign s1_pixel = s1_valid_reg && (s1_reg.kind == OP_PIXEL);
    assign s2_pixel = s2_valid_reg && (s2_kind_reg == OP_PIXEL);
    assign n_flight = 2'(s1_pixel) + 2'(s2_pixel) + 2'(s3_valid_reg);
    assign used     = (OCW+1)'(out_count) + (OCW+1)'(n_flight);

    // a pixel leaves the queue only with a free output slot reserved for it
    assign mq_pop = !mq_empty
                 && ((mq_item.kind != OP_PIXEL) || (used < (OCW+1)'(OUT_DEPTH)));

    assign pos       = 15'(s1_reg.dy) * 15'(geom.cur_w) + 15'(s1_reg.dx);
    assign pos_ok    = pos < 15'(CURSOR_PIXELS);
    assign row_sum   = geom.oy + 12'(s1_reg.row);
    assign addr_full = FP_W'(row_sum) * FP_W'(CANVAS_WIDTH) + FP_W'(geom.ox)
                     + FP_W'(s1_reg.col);

    assign paddr = (s2_hit_reg && (crd_reg != 8'd0)) ? crd_reg : s2_index_reg;

    assign op_push               = s3_valid_reg;
    assign op_item.frame_address = s3_addr_reg;
    assign op_item.rgb565        = prd_reg;
    assign op_item.frame_last    = s3_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= mq_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= mq_item;
        s2_kind_reg  <= s1_reg.kind;
        s2_index_reg <= s1_reg.index;
        s2_pslot_reg <= s1_reg.pslot;
        s2_entry_reg <= s1_reg.entry;
        s2_hit_reg   <= s1_reg.hit && pos_ok;
        s2_addr_reg  <= addr_full[ADDR_W-1:0];
        s2_last_reg  <= s1_reg.last;
        s3_addr_reg  <= s2_addr_reg;
        s3_last_reg  <= s2_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && (s1_reg.kind == OP_CURSOR))
        begin
            cmem[s1_reg.cpos[CA_W-1:0]] <= s1_reg.index;
        end
        if (s1_pixel && pos_ok)
        begin
            crd_reg <= cmem[pos[CA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && (s2_kind_reg == OP_PALETTE))
        begin
            pmem[s2_pslot_reg] <= s2_entry_reg;
        end
        if (s2_pixel)
        begin
            prd_reg <= pmem[paddr];
        end
    end

endmodule

// File: sv/palette_display_cursor_overlay.sv
// Paletted page to RGB565 canvas converter with a hardware cursor overlay.
// Input queue side: push/full with item. Operation pixel carries a palette
// index for the next raster position; palette writes and cursor image writes
// update the stores in order with the pixel stream and give no result.
// Result queue side: empty/pop with result; one result per page pixel that
// lands inside the centred canvas window, frame_last on its last pixel.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while the block is idle.
// Throughput is one item per clock while full stays low. A result follows its
// pixel transfer along this path: the front classifies into a 4-entry queue,
// the back runs a cursor store read, a palette read and an output register
// stage into an 8-entry result queue.
// Reset clears the raster counters, both queues and the configuration to its
// defaults; the palette and cursor stores are not cleared.
// When pop is held low the result queue fills, pixels wait in the front queue
// and full rises once that queue is full; nothing is dropped.
module palette_display_cursor_overlay #(
    parameter int CANVAS_WIDTH  = 800,
    parameter int CANVAS_HEIGHT = 480,
    parameter int CURSOR_PIXELS = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  pdco_pkg::in_item_t    item,
    output logic                  empty,
    input  logic                  pop,
    output pdco_pkg::out_item_t   result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [10:0]           cfg_data
);
    import pdco_pkg::*;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam logic [11:0] CW12 = 12'(CANVAS_WIDTH);
    localparam logic [11:0] CH12 = 12'(CANVAS_HEIGHT);

    logic [10:0]        pw_reg, ph_reg;
    logic [6:0]         cur_w_reg, cur_h_reg;
    logic signed [10:0] cur_left_reg, cur_top_reg;
    logic [13:0]        cprod;
    geom_t              geom;

    logic                          mq_push, mq_full, mq_empty, mq_pop;
    mid_item_t                     mq_in, mq_out;
    logic [$clog2(MID_DEPTH+1)-1:0] mq_count;
    logic                          op_push, out_full;
    out_item_t                     op_item;
    logic [$bits(out_item_t)-1:0]  out_rdata;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg       <= 11'd640;
            ph_reg       <= 11'd400;
            cur_w_reg    <= '0;
            cur_h_reg    <= '0;
            cur_left_reg <= '0;
            cur_top_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PAGE_WIDTH:    pw_reg       <= clamp_size(cfg_data);
                CFG_PAGE_HEIGHT:   ph_reg       <= clamp_size(cfg_data);
                CFG_CURSOR_WIDTH:  cur_w_reg    <= cfg_data[6:0];
                CFG_CURSOR_HEIGHT: cur_h_reg    <= cfg_data[6:0];
                CFG_CURSOR_LEFT:   cur_left_reg <= $signed(cfg_data);
                CFG_CURSOR_TOP:    cur_top_reg  <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    assign cprod = 14'(cur_w_reg) * 14'(cur_h_reg);

    always_comb
    begin
        geom.pw       = pw_reg;
        geom.ph       = ph_reg;
        geom.cw       = ({1'b0, pw_reg} < CW12) ? {1'b0, pw_reg} : CW12;
        geom.ch       = ({1'b0, ph_reg} < CH12) ? {1'b0, ph_reg} : CH12;
        // page centred on the canvas, rounded toward the top left
        geom.ox       = ({1'b0, pw_reg} < CW12) ? ((CW12 - {1'b0, pw_reg}) >> 1) : 12'd0;
        geom.oy       = ({1'b0, ph_reg} < CH12) ? ((CH12 - {1'b0, ph_reg}) >> 1) : 12'd0;
        geom.cur_w    = cur_w_reg;
        geom.cur_h    = cur_h_reg;
        geom.cur_left = cur_left_reg;
        geom.cur_top  = cur_top_reg;
        geom.cur_ok   = {1'b0, cprod} <= 15'(CURSOR_PIXELS);
    end

    pdco_front #(
        .CURSOR_PIXELS (CURSOR_PIXELS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .geom    (geom),
        .mq_push (mq_push),
        .mq_item (mq_in),
        .mq_full (mq_full)
    );

    pdco_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mq_push),
        .wdata (mq_in),
        .full  (mq_full),
        .rd    (mq_pop),
        .rdata (mq_out),
        .empty (mq_empty),
        .count (mq_count)
    );

    pdco_back #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CURSOR_PIXELS (CURSOR_PIXELS),
        .OUT_DEPTH     (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mq_empty  (mq_empty),
        .mq_item   (mq_out),
        .mq_pop    (mq_pop),
        .geom      (geom),
        .out_count (out_count),
        .op_push   (op_push),
        .op_item   (op_item)
    );

    pdco_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (op_push),
        .wdata (op_item),
        .full  (out_full),
        .rd    (pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign result = out_item_t'(out_rdata);

    // the back reserves a result slot before a pixel leaves the front queue
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        op_push |-> !out_full)
        else $error("result queue overflow");

    a_front_depth: assert property (@(posedge clk) disable iff (!rst_n)
        mq_push |-> (mq_count < 3'(MID_DEPTH)))
        else $error("front queue written while full");

    a_hit_needs_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (mq_push && (mq_in.kind == OP_PIXEL) && mq_in.hit)
        |-> (geom.cur_ok && (geom.cur_w != 7'd0) && (geom.cur_h != 7'd0)))
        else $error("cursor hit with cursor disabled");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        op_push |-> $past(mq_pop, 3))
        else $error("result without a matching front queue transfer");

endmodule
